// ----- rtl/core/lft_pkg.sv -----
// Shared types and constants for the LRU frame replacement table.
package lft_pkg;

  localparam int FIDX_W     = 6;
  localparam int PAGE_IN_W  = 20;
  localparam int TIME_W     = 31;
  localparam int STATUS_W   = 2;
  localparam int FAULT_W    = 32;
  localparam int CNT_CFG_W  = 7;

  localparam logic [CNT_CFG_W-1:0] CNT_RESET = 7'd64;

  localparam logic [STATUS_W-1:0] ST_HIT   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FAULT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ERROR = 2'd2;

  typedef struct packed {
    logic clear;
    logic load;
    logic update;
    logic scan;
    logic out_load;
  } lft_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic scan_done;
    logic out_free;
  } lft_stat_t;

endpackage

// ----- rtl/core/lft_if.sv -----
// Request and response channel interfaces of the LRU frame replacement table.
interface lft_req_if;
  import lft_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [FIDX_W-1:0]    frame_index;
  logic [PAGE_IN_W-1:0] page_number;
  logic [TIME_W-1:0]    access_time;

  modport source (output valid, frame_index, page_number, access_time, input ready);
  modport sink (input valid, frame_index, page_number, access_time, output ready);
endinterface

interface lft_rsp_if;
  import lft_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [FAULT_W-1:0]  fault_total;
  logic [FIDX_W-1:0]   victim_frame;

  modport source (output valid, status, fault_total, victim_frame, input ready);
  modport sink (input valid, status, fault_total, victim_frame, output ready);
endinterface

// ----- rtl/core/lft_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module lft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/lft_ctrl.sv -----
// Sequencing state machine of the LRU frame replacement table.
module lft_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lft_pkg::lft_stat_t stat,
  output lft_pkg::lft_cmd_t  cmd
);
  import lft_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOOK  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    in_ready     = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.update = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/lft_dpath.sv -----
// Frame table storage, fault counter, victim scan and result register.
module lft_dpath #(
  parameter int FRAMES     = 64,
  parameter int PAGE_WIDTH = 20
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [lft_pkg::CNT_CFG_W-1:0]  cfg_wdata,
  input  logic [lft_pkg::FIDX_W-1:0]     frame_index,
  input  logic [lft_pkg::PAGE_IN_W-1:0]  page_number,
  input  logic [lft_pkg::TIME_W-1:0]     access_time,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [lft_pkg::STATUS_W-1:0]   status,
  output logic [lft_pkg::FAULT_W-1:0]    fault_total,
  output logic [lft_pkg::FIDX_W-1:0]     victim_frame,
  input  lft_pkg::lft_cmd_t              cmd,
  output lft_pkg::lft_stat_t             stat
);
  import lft_pkg::*;

  localparam int AW  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int NW  = $clog2(FRAMES + 1);
  localparam int CW  = (NW > CNT_CFG_W) ? NW : CNT_CFG_W;
  localparam int PXW = (PAGE_WIDTH > PAGE_IN_W) ? PAGE_WIDTH : PAGE_IN_W;
  localparam int DW  = 1 + PAGE_WIDTH + TIME_W;

  logic [CNT_CFG_W-1:0]  frame_count;
  logic [FAULT_W-1:0]    fault_cnt;
  logic [AW-1:0]         fidx_r;
  logic [PAGE_WIDTH-1:0] page_r;
  logic [TIME_W-1:0]     time_r;
  logic                  err_r;
  logic [STATUS_W-1:0]   status_r;
  logic [NW-1:0]         addr_cnt;
  logic                  rd_pend;
  logic [AW-1:0]         rd_idx;
  logic                  have_best;
  logic [TIME_W-1:0]     best_time;
  logic [AW-1:0]         best_idx;

  logic [CW-1:0]         cnt_ext;
  logic [CW-1:0]         frames_ext;
  logic [CW-1:0]         n_full;
  logic [NW-1:0]         n_act;
  logic [CW-1:0]         fidx_ext;
  logic [PXW-1:0]        page_ext;
  logic [CW-1:0]         victim_ext;
  logic                  in_err;
  logic                  scan_more;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DW-1:0]         ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [DW-1:0]         ram_rdata;
  logic                  r_valid;
  logic [PAGE_WIDTH-1:0] r_page;
  logic [TIME_W-1:0]     r_time;
  logic                  hit;

  assign cnt_ext    = CW'(frame_count);
  assign frames_ext = CW'(FRAMES);
  assign n_full     = (cnt_ext > frames_ext) ? frames_ext : cnt_ext;
  assign n_act      = n_full[NW-1:0];
  assign fidx_ext   = CW'(frame_index);
  assign page_ext   = PXW'(page_number);
  assign in_err     = (frame_index == '0) || (fidx_ext >= n_full);
  assign scan_more  = addr_cnt < n_act;
  assign victim_ext = CW'(best_idx);

  assign r_valid = ram_rdata[DW-1];
  assign r_page  = ram_rdata[TIME_W +: PAGE_WIDTH];
  assign r_time  = ram_rdata[TIME_W-1:0];
  assign hit     = r_valid && (r_page == page_r);

  assign ram_we    = cmd.clear || (cmd.update && !err_r);
  assign ram_waddr = cmd.clear ? addr_cnt[AW-1:0] : fidx_r;
  assign ram_wdata = cmd.clear ? '0 : {1'b1, page_r, time_r};
  assign ram_raddr = cmd.load ? fidx_ext[AW-1:0] : addr_cnt[AW-1:0];

  assign stat.clear_last = addr_cnt == NW'(FRAMES - 1);
  assign stat.scan_done  = !scan_more && !rd_pend;
  assign stat.out_free   = !out_valid || out_ready;

  lft_ram #(
    .WIDTH (DW),
    .DEPTH (FRAMES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= CNT_RESET;
    end else if (cfg_we) begin
      frame_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fault_cnt <= '0;
      addr_cnt  <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear) begin
        addr_cnt <= addr_cnt + NW'(1);
      end
      if (cmd.update) begin
        addr_cnt <= NW'(1);
        rd_pend  <= 1'b0;
        if (!err_r && !hit && (fault_cnt != '1)) begin
          fault_cnt <= fault_cnt + FAULT_W'(1);
        end
      end
      if (cmd.scan) begin
        rd_pend <= scan_more;
        if (scan_more) begin
          addr_cnt <= addr_cnt + NW'(1);
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fidx_r <= fidx_ext[AW-1:0];
      page_r <= page_ext[PAGE_WIDTH-1:0];
      time_r <= access_time;
      err_r  <= in_err;
    end
    if (cmd.update) begin
      have_best <= 1'b0;
      best_idx  <= AW'(1);
      if (err_r) begin
        status_r <= ST_ERROR;
      end else if (hit) begin
        status_r <= ST_HIT;
      end else begin
        status_r <= ST_FAULT;
      end
    end
    if (cmd.scan) begin
      rd_idx <= addr_cnt[AW-1:0];
      if (rd_pend && (!have_best || (r_time < best_time))) begin
        have_best <= 1'b1;
        best_time <= r_time;
        best_idx  <= rd_idx;
      end
    end
    if (cmd.out_load) begin
      status       <= status_r;
      fault_total  <= fault_cnt;
      victim_frame <= victim_ext[FIDX_W-1:0];
    end
  end

endmodule

// ----- rtl/core/lru_frame_replacement_table.sv -----
// Top level of the LRU frame replacement table.
// Each request names a frame, a page and a time stamp; the block refreshes the time on a hit or
// loads the page and counts a fault otherwise, and reports an error for frame 0 or a frame of n or
// above. It then scans the time stamps of frames 1 to n-1 (n being the smaller of frame_count and
// FRAMES) one table read per cycle to find the least recently used frame, lowest index on ties.
// The next request is taken once the response to the last one is in the output register. After
// reset the table is cleared one entry per cycle, and no request is accepted until it is done;
// configuration writes are taken at any time.
module lru_frame_replacement_table #(
  parameter int FRAMES     = 64,
  parameter int PAGE_WIDTH = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lft_pkg::CNT_CFG_W-1:0] cfg_wdata,
  lft_req_if.sink                       req,
  lft_rsp_if.source                     rsp
);
  import lft_pkg::*;

  lft_cmd_t  cmd;
  lft_stat_t stat;

  lft_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lft_dpath #(
    .FRAMES     (FRAMES),
    .PAGE_WIDTH (PAGE_WIDTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .frame_index  (req.frame_index),
    .page_number  (req.page_number),
    .access_time  (req.access_time),
    .out_ready    (rsp.ready),
    .out_valid    (rsp.valid),
    .status       (rsp.status),
    .fault_total  (rsp.fault_total),
    .victim_frame (rsp.victim_frame),
    .cmd          (cmd),
    .stat         (stat)
  );

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while an item is still in progress");

  a_fault_counted: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == ST_FAULT) |-> rsp.fault_total != '0)
    else $error("fault reported with a zero fault count");

  a_clear_first: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !req.ready)
    else $error("request accepted before the table was cleared");

  a_no_lookup_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |-> !cmd.load && !cmd.update && !cmd.clear)
    else $error("table lookup overlaps the victim scan");
`endif

endmodule

// ----- verif/tb_lru_frame_replacement_table.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the LRU frame replacement table: directed table, then random traffic.
module tb_lru_frame_replacement_table;
  import lft_pkg::*;

  localparam int NFRAMES = 64;
  localparam int CLK_HALF = 4;
  localparam int RAND_ITEMS = 1250;
  localparam int PHASES = 8;
  localparam int ROWS = 20;
  localparam int HOLD_CYCLES = 400;
  localparam logic [PAGE_IN_W-1:0] PMAX = '1;
  localparam logic [TIME_W-1:0] TMAX = '1;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FAULT_W-1:0]  fault_total;
    logic [FIDX_W-1:0]   victim_frame;
  } lru_result_t;

  typedef struct packed {
    logic                 set_cfg;
    logic [CNT_CFG_W-1:0] cfg;
    logic [FIDX_W-1:0]    frame;
    logic [PAGE_IN_W-1:0] page;
    logic [TIME_W-1:0]    stamp;
    logic                 typed;
    lru_result_t          result;
  } access_row_t;

  localparam lru_result_t NONE = '0;

  access_row_t access_rows [0:ROWS-1] = '{
    '{1'b0, 7'd0, 6'd0, 20'd0, 31'd0, 1'b1, '{ST_ERROR, 32'd0, 6'd1}},
    '{1'b0, 7'd0, 6'd1, 20'd0, 31'd0, 1'b1, '{ST_FAULT, 32'd1, 6'd1}},
    '{1'b0, 7'd0, 6'd1, 20'd0, 31'd0, 1'b1, '{ST_HIT, 32'd1, 6'd1}},
    '{1'b0, 7'd0, 6'd63, PMAX, TMAX, 1'b1, '{ST_FAULT, 32'd2, 6'd1}},
    '{1'b0, 7'd0, 6'd63, PMAX, TMAX, 1'b1, '{ST_HIT, 32'd2, 6'd1}},
    '{1'b0, 7'd0, 6'd63, 20'd0, 31'd0, 1'b1, '{ST_FAULT, 32'd3, 6'd1}},
    '{1'b0, 7'd0, 6'd1, 20'd0, TMAX, 1'b1, '{ST_HIT, 32'd3, 6'd2}},
    '{1'b0, 7'd0, 6'd42, 20'h55555, 31'h2AAAAAAA, 1'b0, NONE},
    '{1'b0, 7'd0, 6'd21, 20'hAAAAA, 31'h55555555, 1'b0, NONE},
    '{1'b1, 7'd127, 6'd62, 20'd1, 31'd3, 1'b0, NONE},
    '{1'b0, 7'd0, 6'd63, 20'd1, 31'd1, 1'b0, NONE},
    '{1'b1, 7'd2, 6'd1, 20'd0, 31'd9, 1'b0, NONE},
    '{1'b0, 7'd0, 6'd2, 20'd0, 31'd9, 1'b0, NONE},
    '{1'b1, 7'd1, 6'd1, 20'd0, 31'd9, 1'b0, NONE},
    '{1'b1, 7'd0, 6'd0, 20'd0, 31'd0, 1'b0, NONE},
    '{1'b1, 7'd3, 6'd2, 20'd7, 31'd0, 1'b0, NONE},
    '{1'b0, 7'd0, 6'd3, 20'd7, 31'd0, 1'b0, NONE},
    '{1'b1, 7'd64, 6'd30, 20'h12345, 31'd0, 1'b0, NONE},
    '{1'b0, 7'd0, 6'd31, 20'h12345, TMAX, 1'b0, NONE},
    '{1'b0, 7'd0, 6'd0, PMAX, TMAX, 1'b0, NONE}
  };

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CNT_CFG_W-1:0] cfg_wdata;

  lft_req_if req_if ();
  lft_rsp_if rsp_if ();

  lru_frame_replacement_table u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .req(req_if),
    .rsp(rsp_if)
  );

  logic [PAGE_IN_W-1:0] model_page [NFRAMES];
  logic                 model_valid [NFRAMES];
  logic [TIME_W-1:0]    model_time [NFRAMES];
  logic [FAULT_W-1:0]   model_faults;
  logic [CNT_CFG_W-1:0] model_count;

  lru_result_t pending_rsp [$];
  lru_result_t want_res;

  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent = 0;
  int unsigned cfg_writes = 0;
  int unsigned hits_seen = 0;
  int unsigned faults_seen = 0;
  int unsigned rejects_seen = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  bit hold_request = 1'b0;

  always #CLK_HALF clk = ~clk;

  function automatic lru_result_t lru_table_update(input logic [FIDX_W-1:0] f,
                                                   input logic [PAGE_IN_W-1:0] p,
                                                   input logic [TIME_W-1:0] s);
    lru_result_t r;
    int n;
    int best;
    n = (model_count > NFRAMES) ? NFRAMES : int'(model_count);
    if (f == 0 || int'(f) >= n) begin
      r.status = ST_ERROR;
    end else if (model_valid[f] && model_page[f] == p) begin
      model_time[f] = s;
      r.status = ST_HIT;
    end else begin
      model_page[f] = p;
      model_valid[f] = 1'b1;
      model_time[f] = s;
      if (model_faults != '1) model_faults = model_faults + 1;
      r.status = ST_FAULT;
    end
    best = 1;
    for (int i = 2; i < n; i++) begin
      if (model_time[i] < model_time[best]) best = i;
    end
    r.fault_total = model_faults;
    r.victim_frame = best[FIDX_W-1:0];
    return r;
  endfunction

  task automatic offer_access(input logic [FIDX_W-1:0] f, input logic [PAGE_IN_W-1:0] p,
                              input logic [TIME_W-1:0] s, input bit typed,
                              input lru_result_t typed_res);
    lru_result_t r;
    req_if.valid <= 1'b1;
    req_if.frame_index <= f;
    req_if.page_number <= p;
    req_if.access_time <= s;
    do @(posedge clk); while (!req_if.ready);
    r = lru_table_update(f, p, s);
    pending_rsp.push_back(typed ? typed_res : r);
    items_sent++;
  endtask

  task automatic sender_gap();
    int n;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      if ($urandom_range(7) == 0) begin
        n = $urandom_range(90, 1);
      end else begin
        n = 1;
        while ($urandom_range(99) < idle_pct) n++;
      end
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic write_frame_count(input logic [CNT_CFG_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_count = v;
    cfg_writes++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      results_seen++;
      case (rsp_if.status)
        ST_HIT: hits_seen++;
        ST_FAULT: faults_seen++;
        default: rejects_seen++;
      endcase
      if (pending_rsp.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected result, expected none, got status %0d fault_total %0d victim %0d",
                 $time, rsp_if.status, rsp_if.fault_total, rsp_if.victim_frame);
      end else begin
        want_res = pending_rsp.pop_front();
        check_field("status", 32'(want_res.status), 32'(rsp_if.status));
        check_field("fault_total", want_res.fault_total, rsp_if.fault_total);
        check_field("victim_frame", 32'(want_res.victim_frame), 32'(rsp_if.victim_frame));
      end
    end
  end

  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    #8_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [FIDX_W-1:0] f;
    logic [PAGE_IN_W-1:0] p;
    logic [TIME_W-1:0] s;
    logic [TIME_W-1:0] now_stamp;
    logic [CNT_CFG_W-1:0] phase_count;
    int n_eff;
    int sel;
    int per_phase;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_if.valid = 1'b0;
    req_if.frame_index = '0;
    req_if.page_number = '0;
    req_if.access_time = '0;
    for (int i = 0; i < NFRAMES; i++) begin
      model_page[i] = '0;
      model_valid[i] = 1'b0;
      model_time[i] = '0;
    end
    model_faults = '0;
    model_count = CNT_RESET;
    now_stamp = '0;
    per_phase = RAND_ITEMS / PHASES;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < ROWS; r++) begin
      if (access_rows[r].set_cfg) begin
        drain_results();
        write_frame_count(access_rows[r].cfg);
      end
      offer_access(access_rows[r].frame, access_rows[r].page, access_rows[r].stamp,
                   access_rows[r].typed, access_rows[r].result);
    end
    drain_results();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 78; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 78; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      case (ph)
        0: phase_count = 7'd64;
        1: phase_count = 7'd2;
        2: phase_count = 7'd127;
        3: phase_count = 7'd5;
        4: phase_count = 7'd17;
        5: phase_count = 7'd64;
        6: phase_count = 7'd100;
        default: phase_count = CNT_CFG_W'($urandom_range(64, 2));
      endcase
      write_frame_count(phase_count);
      n_eff = (model_count > NFRAMES) ? NFRAMES : int'(model_count);

      for (int k = 0; k < per_phase; k++) begin
        if (ph == 0 && k == 40) hold_request = 1'b1;
        if (ph == 1 && k == 60) drain_results();

        if (n_eff >= 2 && $urandom_range(99) < 85) f = FIDX_W'($urandom_range(n_eff - 1, 1));
        else f = FIDX_W'($urandom_range(NFRAMES - 1));

        sel = $urandom_range(99);
        if (model_valid[f] && sel < 50) p = model_page[f];
        else if (sel < 65) p = PAGE_IN_W'($urandom_range(3));
        else p = PAGE_IN_W'($urandom);

        sel = $urandom_range(99);
        if (sel < 60) begin
          now_stamp = now_stamp + TIME_W'($urandom_range(3));
          s = now_stamp;
        end else if (sel < 80) begin
          s = TIME_W'($urandom);
        end else if (sel < 90) begin
          s = '0;
        end else begin
          s = TMAX;
        end

        offer_access(f, p, s, 1'b0, NONE);
        sender_gap();
      end
      drain_results();
    end

    repeat (100) @(posedge clk);
    $display("Sent %0d items across %0d frame-count settings and checked %0d results.",
             items_sent, cfg_writes, results_seen);
    $display("Outcomes seen: %0d hits, %0d page loads, %0d rejected frames.",
             hits_seen, faults_seen, rejects_seen);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
